@@ sv/bmpd_pkg.sv @@
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the 24-bit BMP to ARGB decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpd_pkg;

   // Image size limit and derived field widths
   localparam logic [31:0] MAX_DIM = 32'd1024;
   localparam int          DIM_W   = 11;
   localparam int          COORD_W = 10;

   // Header byte positions (last byte of each little-endian field)
   localparam logic [31:0] POS_SIG_B       = 32'd0;
   localparam logic [31:0] POS_SIG_M       = 32'd1;
   localparam logic [31:0] POS_OFFSET_LAST = 32'd13;
   localparam logic [31:0] POS_WIDTH_LAST  = 32'd21;
   localparam logic [31:0] POS_HEIGHT_LAST = 32'd25;
   localparam logic [31:0] POS_BPP_LAST    = 32'd29;
   localparam logic [31:0] POS_COMP_LAST   = 32'd33;
   localparam logic [31:0] HDR_LEN         = 32'd54;
   localparam logic [31:0] HDR_LAST        = 32'd53;

   // Header field values
   localparam logic [7:0]  SIG_B    = 8'h42;
   localparam logic [7:0]  SIG_M    = 8'h4D;
   localparam logic [15:0] BPP_24   = 16'd24;
   localparam logic [7:0]  BYTE_MAX = 8'hFF;
   localparam logic [7:0]  BYTE_MIN = 8'h00;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;

   // Item kinds
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Final status codes
   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_SIG     = 2'd1,
      ST_UNSUPPORTED = 2'd2,
      ST_TRUNCATED   = 2'd3
   } bmpd_status_type;

   // One result item
   typedef struct packed {
      logic                 item_kind;
      logic [31:0]          pixel_argb;
      logic [COORD_W-1:0]   pixel_x;
      logic [COORD_W-1:0]   pixel_y;
      logic [DIM_W-1:0]     image_width;
      logic [DIM_W-1:0]     image_height;
      bmpd_status_type      decode_status;
      logic                 last_item;
   } bmpd_item_type;

   // Items pushed by the parser in one cycle, first before second
   typedef struct packed {
      logic [1:0]    cnt;
      bmpd_item_type first;
      bmpd_item_type second;
   } bmpd_push_type;

endpackage

`default_nettype wire

@@ sv/bmpd_if.sv @@
// ----------------------------------------------------------------------------
// bmpd_if
// Valid/ready channel interfaces of the BMP decoder: byte input, result
// output and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       end_of_file;

   modport source (output valid, output file_byte, output end_of_file, input ready);
   modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

interface bmpd_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [31:0] pixel_argb;
   logic [9:0]  pixel_x;
   logic [9:0]  pixel_y;
   logic [10:0] image_width;
   logic [10:0] image_height;
   logic [1:0]  decode_status;
   logic        last_item;

   modport source (output valid, output item_kind, output pixel_argb, output pixel_x,
                   output pixel_y, output image_width, output image_height,
                   output decode_status, output last_item, input ready);
   modport sink   (input valid, input item_kind, input pixel_argb, input pixel_x,
                   input pixel_y, input image_width, input image_height,
                   input decode_status, input last_item, output ready);
endinterface

interface bmpd_csr_if;
   logic valid;
   logic ready;
   logic color_key_enable;

   modport source (output valid, output color_key_enable, input ready);
   modport sink   (input valid, input color_key_enable, output ready);
endinterface

`default_nettype wire

@@ sv/bmpd_parser.sv @@
// ----------------------------------------------------------------------------
// bmpd_parser
// Byte-at-a-time BMP parser: header capture and check, offset skip, row
// padding drop and pixel assembly. Emits up to two items per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpd_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   bmpd_req_if.sink                     req_if,
   input  wire logic                    key_enable,
   input  wire logic                    space_ok,
   output      bmpd_pkg::bmpd_push_type push
);

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_SKIP   = 3'd1,
      PH_PIXELS = 3'd2,
      PH_DONE   = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   localparam int DW = bmpd_pkg::DIM_W;
   localparam int CW = bmpd_pkg::COORD_W;

   phase_type                 phase_ff,  phase_in;
   logic [31:0]               pos_ff,    pos_in;
   logic [31:0]               asm_ff,    asm_in;
   logic [31:0]               offset_ff, offset_in;
   logic                      bpp_ok_ff, bpp_ok_in;
   logic                      comp_ok_ff, comp_ok_in;
   logic                      w_ok_ff,   w_ok_in;
   logic                      h_ok_ff,   h_ok_in;
   logic [DW-1:0]             width_ff,  width_in;
   logic [DW-1:0]             height_ff, height_in;
   logic                      top_ff,    top_in;
   logic [11:0]               rbi_ff,    rbi_in;
   logic [1:0]                k_ff,      k_in;
   logic [CW-1:0]             x_ff,      x_in;
   logic [DW-1:0]             row_ff,    row_in;
   logic [7:0]                blue_ff,   blue_in;
   logic [7:0]                green_ff,  green_in;
   bmpd_pkg::bmpd_status_type err_ff,    err_in;

   logic                    fire;
   logic [7:0]              b;
   logic [31:0]             asm_next;
   logic [31:0]             h_mag;
   logic                    hdr_good;
   logic                    pix_go;
   logic                    emit;
   logic [11:0]             data_bytes;
   logic [11:0]             padded_len;
   logic [11:0]             rbi_inc;
   logic [DW-1:0]           row_inc;
   logic [DW-1:0]           y_full;
   logic [7:0]              alpha;
   logic                    accepted_after;
   bmpd_pkg::bmpd_item_type pix_item;
   bmpd_pkg::bmpd_item_type st_item;

   assign req_if.ready = space_ok;
   assign fire         = req_if.valid && space_ok;
   assign b            = req_if.file_byte;

   // Row geometry: three bytes per pixel, rounded up to a multiple of four
   assign data_bytes = {width_ff, 1'b0} + {1'b0, width_ff};
   assign padded_len = (data_bytes + 12'd3) & ~12'd3;
   assign rbi_inc    = rbi_ff + 12'd1;
   assign row_inc    = row_ff + DW'(1);

   // Header field assembly and checks
   assign asm_next = {b, asm_ff[31:8]};
   assign h_mag    = asm_next[31] ? (~asm_next + 32'd1) : asm_next;
   assign hdr_good = bpp_ok_ff && comp_ok_ff && w_ok_ff && h_ok_ff &&
                     (offset_ff >= bmpd_pkg::HDR_LEN);

   // Next-state logic for one accepted byte
   always_comb begin
      phase_in   = phase_ff;
      pos_in     = (pos_ff == 32'hFFFF_FFFF) ? pos_ff : pos_ff + 32'd1;
      asm_in     = asm_ff;
      offset_in  = offset_ff;
      bpp_ok_in  = bpp_ok_ff;
      comp_ok_in = comp_ok_ff;
      w_ok_in    = w_ok_ff;
      h_ok_in    = h_ok_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      top_in     = top_ff;
      rbi_in     = rbi_ff;
      k_in       = k_ff;
      x_in       = x_ff;
      row_in     = row_ff;
      blue_in    = blue_ff;
      green_in   = green_ff;
      err_in     = err_ff;
      pix_go     = 1'b0;
      emit       = 1'b0;

      unique case (phase_ff)
         PH_HEADER: begin
            asm_in = asm_next;
            if ((pos_ff == bmpd_pkg::POS_SIG_B && b != bmpd_pkg::SIG_B) ||
                (pos_ff == bmpd_pkg::POS_SIG_M && b != bmpd_pkg::SIG_M)) begin
               err_in   = bmpd_pkg::ST_BAD_SIG;
               phase_in = PH_ERROR;
            end else begin
               if (pos_ff == bmpd_pkg::POS_OFFSET_LAST) begin
                  offset_in = asm_next;
               end
               if (pos_ff == bmpd_pkg::POS_WIDTH_LAST) begin
                  width_in = asm_next[DW-1:0];
                  w_ok_in  = !asm_next[31] && (asm_next != 32'd0) &&
                             (asm_next <= bmpd_pkg::MAX_DIM);
               end
               if (pos_ff == bmpd_pkg::POS_HEIGHT_LAST) begin
                  top_in    = asm_next[31];
                  height_in = h_mag[DW-1:0];
                  h_ok_in   = (h_mag != 32'd0) && (h_mag <= bmpd_pkg::MAX_DIM);
               end
               if (pos_ff == bmpd_pkg::POS_BPP_LAST) begin
                  bpp_ok_in = (asm_next[31:16] == bmpd_pkg::BPP_24);
               end
               if (pos_ff == bmpd_pkg::POS_COMP_LAST) begin
                  comp_ok_in = (asm_next == 32'd0);
               end
               if (pos_ff == bmpd_pkg::HDR_LAST) begin
                  if (!hdr_good) begin
                     err_in   = bmpd_pkg::ST_UNSUPPORTED;
                     phase_in = PH_ERROR;
                  end else if (offset_ff == bmpd_pkg::HDR_LEN) begin
                     phase_in = PH_PIXELS;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
         end
         PH_SKIP: begin
            if (pos_ff == offset_ff) begin
               phase_in = PH_PIXELS;
               pix_go   = 1'b1;
            end
         end
         PH_PIXELS: begin
            pix_go = 1'b1;
         end
         PH_DONE: begin
         end
         PH_ERROR: begin
         end
         default: begin
         end
      endcase

      // Pixel bytes: collect B and G, emit on R, drop padding
      if (pix_go) begin
         if (rbi_ff < data_bytes) begin
            unique case (k_ff)
               2'd0: begin
                  blue_in = b;
                  k_in    = 2'd1;
               end
               2'd1: begin
                  green_in = b;
                  k_in     = 2'd2;
               end
               default: begin
                  emit = 1'b1;
                  k_in = 2'd0;
                  x_in = x_ff + CW'(1);
               end
            endcase
         end
         rbi_in = rbi_inc;
         if (rbi_inc >= padded_len) begin
            rbi_in = 12'd0;
            k_in   = 2'd0;
            x_in   = '0;
            row_in = row_inc;
            if (row_inc >= height_ff) begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   // Pixel item
   assign y_full = top_ff ? row_ff : (height_ff - DW'(1) - row_ff);
   assign alpha  = (key_enable && b == bmpd_pkg::BYTE_MAX && green_ff == bmpd_pkg::BYTE_MIN &&
                    blue_ff == bmpd_pkg::BYTE_MAX) ? bmpd_pkg::ALPHA_CLEAR
                                                   : bmpd_pkg::ALPHA_OPAQUE;

   always_comb begin
      pix_item               = '0;
      pix_item.item_kind     = bmpd_pkg::KIND_PIXEL;
      pix_item.pixel_argb    = {alpha, b, green_ff, blue_ff};
      pix_item.pixel_x       = x_ff;
      pix_item.pixel_y       = y_full[CW-1:0];
      pix_item.image_width   = width_ff;
      pix_item.image_height  = height_ff;
      pix_item.decode_status = bmpd_pkg::ST_OK;
      pix_item.last_item     = 1'b0;
   end

   // Status item, sized only once the header has passed
   assign accepted_after = (phase_in == PH_SKIP) || (phase_in == PH_PIXELS) ||
                           (phase_in == PH_DONE);

   always_comb begin
      st_item              = '0;
      st_item.item_kind    = bmpd_pkg::KIND_STATUS;
      st_item.image_width  = accepted_after ? width_in  : '0;
      st_item.image_height = accepted_after ? height_in : '0;
      st_item.last_item    = 1'b1;
      if (err_in != bmpd_pkg::ST_OK) begin
         st_item.decode_status = err_in;
      end else if (phase_in == PH_DONE) begin
         st_item.decode_status = bmpd_pkg::ST_OK;
      end else begin
         st_item.decode_status = bmpd_pkg::ST_TRUNCATED;
      end
   end

   // Order the pushed items: pixel first, status after it
   always_comb begin
      push.cnt    = 2'd0;
      push.first  = emit ? pix_item : st_item;
      push.second = st_item;
      if (fire) begin
         push.cnt = {1'b0, emit} + {1'b0, req_if.end_of_file};
      end
   end

   // Hold parser state; a final byte returns everything to header phase
   always_ff @(posedge clock) begin
      if (reset || (fire && req_if.end_of_file)) begin
         phase_ff   <= PH_HEADER;
         pos_ff     <= '0;
         asm_ff     <= '0;
         offset_ff  <= '0;
         bpp_ok_ff  <= 1'b0;
         comp_ok_ff <= 1'b0;
         w_ok_ff    <= 1'b0;
         h_ok_ff    <= 1'b0;
         width_ff   <= '0;
         height_ff  <= '0;
         top_ff     <= 1'b0;
         rbi_ff     <= '0;
         k_ff       <= '0;
         x_ff       <= '0;
         row_ff     <= '0;
         blue_ff    <= '0;
         green_ff   <= '0;
         err_ff     <= bmpd_pkg::ST_OK;
      end else if (fire) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         asm_ff     <= asm_in;
         offset_ff  <= offset_in;
         bpp_ok_ff  <= bpp_ok_in;
         comp_ok_ff <= comp_ok_in;
         w_ok_ff    <= w_ok_in;
         h_ok_ff    <= h_ok_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         top_ff     <= top_in;
         rbi_ff     <= rbi_in;
         k_ff       <= k_in;
         x_ff       <= x_in;
         row_ff     <= row_in;
         blue_ff    <= blue_in;
         green_ff   <= green_in;
         err_ff     <= err_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/bmpd_out_queue.sv @@
// ----------------------------------------------------------------------------
// bmpd_out_queue
// Three-entry result queue: takes up to two items a cycle, presents one
// registered item on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpd_out_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bmpd_pkg::bmpd_push_type push,
   output      logic                    space_ok,
   bmpd_rsp_if.source                   rsp_if
);

   localparam logic [1:0] DEPTH = 2'd3;

   bmpd_pkg::bmpd_item_type entry_ff [DEPTH];
   logic [1:0]              wr_ff,  wr_in;
   logic [1:0]              rd_ff,  rd_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    pop;
   logic [1:0]              wr_next1;
   bmpd_pkg::bmpd_item_type head;

   function automatic logic [1:0] inc3(input logic [1:0] p);
      inc3 = (p == DEPTH - 2'd1) ? 2'd0 : p + 2'd1;
   endfunction

   // Room for two items: a status may follow a pixel in one cycle
   assign space_ok = (cnt_ff <= DEPTH - 2'd2);
   assign pop      = (cnt_ff != 2'd0) && rsp_if.ready;
   assign wr_next1 = inc3(wr_ff);

   // Advance pointers and fill count
   always_comb begin
      unique case (push.cnt)
         2'd0:    wr_in = wr_ff;
         2'd1:    wr_in = wr_next1;
         default: wr_in = inc3(wr_next1);
      endcase
      rd_in  = pop ? inc3(rd_ff) : rd_ff;
      cnt_in = cnt_ff + push.cnt - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.cnt == 2'd2) begin
         entry_ff[wr_next1] <= push.second;
      end
   end

   // Present the head transaction
   assign head                 = entry_ff[rd_ff];
   assign rsp_if.valid         = (cnt_ff != 2'd0);
   assign rsp_if.item_kind     = head.item_kind;
   assign rsp_if.pixel_argb    = head.pixel_argb;
   assign rsp_if.pixel_x       = head.pixel_x;
   assign rsp_if.pixel_y       = head.pixel_y;
   assign rsp_if.image_width   = head.image_width;
   assign rsp_if.image_height  = head.image_height;
   assign rsp_if.decode_status = head.decode_status;
   assign rsp_if.last_item     = head.last_item;

endmodule

`default_nettype wire

@@ sv/bmp24_to_argb_decoder.sv @@
// ----------------------------------------------------------------------------
// bmp24_to_argb_decoder
// Streams an uncompressed 24-bit BMP file and returns ARGB8888 pixels with
// their coordinates, followed by one status transaction per file.
// ----------------------------------------------------------------------------
//
//   channel  direction  carries
//   -------  ---------  ------------------------------------------------
//   req_if   in         file_byte, end_of_file
//   rsp_if   out        pixel or status item (kind, argb, x, y, size, status)
//   csr_if   in         color_key_enable write
//
// One byte is taken per cycle while the result queue has room; its items
// are registered into the queue, so the first result appears in the cycle
// after the byte. A final byte that also completes a pixel pushes two items;
// the queue then holds req_if.ready low until rsp_if drains it to one item.
// req_if.ready depends on the queue fill count only; csr_if is always ready.
// Synchronous reset clears parser state, queue and color key enable.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp24_to_argb_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   bmpd_req_if.sink   req_if,
   bmpd_rsp_if.source rsp_if,
   bmpd_csr_if.sink   csr_if
);

   logic                    key_enable_ff;
   logic                    key_enable_in;
   logic                    space_ok;
   bmpd_pkg::bmpd_push_type push;

   // Configuration register
   assign csr_if.ready  = 1'b1;
   assign key_enable_in = csr_if.valid ? csr_if.color_key_enable : key_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_enable_ff <= 1'b0;
      end else begin
         key_enable_ff <= key_enable_in;
      end
   end

   bmpd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .key_enable (key_enable_ff),
      .space_ok   (space_ok),
      .push       (push)
   );

   bmpd_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire

@@ sim/bmpd_decode_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_decode_checker
// Watches the byte, result and color key channels of the BMP decoder. Each
// accepted byte runs through a cycle-free copy of the header parser and
// pixel unpacker, and the items it yields are queued. Each accepted result
// is compared field by field with the oldest queued item.
// ----------------------------------------------------------------------------

module bmpd_decode_checker (
   input  logic clock,
   input  logic reset,
   bmpd_req_if  req_mon,
   bmpd_rsp_if  rsp_mon,
   bmpd_csr_if  csr_mon,
   output int   mismatch_count,
   output int   items_awaited
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PIXELS,
      PH_DONE,
      PH_ERROR
   } parse_phase_type;

   // Parser copy and color key setting
   parse_phase_type           phase;
   logic [31:0]               file_pos;
   logic [31:0]               field_acc;
   logic [31:0]               pix_offset;
   logic [15:0]               bpp_seen;
   logic [31:0]               comp_seen;
   logic [31:0]               width_r;
   logic [31:0]               height_r;
   logic                      rows_top_first;
   logic [31:0]               row_byte;
   logic [31:0]               row_idx;
   logic [7:0]                blue_h;
   logic [7:0]                green_h;
   bmpd_pkg::bmpd_status_type error_st;
   logic                      key_enable;

   // Decoded items not yet seen on the result channel
   bmpd_pkg::bmpd_item_type   decoded_q[$];

   function automatic void clear_parser();
      phase          = PH_HEADER;
      file_pos       = '0;
      field_acc      = '0;
      pix_offset     = '0;
      bpp_seen       = '0;
      comp_seen      = '0;
      width_r        = '0;
      height_r       = '0;
      rows_top_first = 1'b0;
      row_byte       = '0;
      row_idx        = '0;
      blue_h         = '0;
      green_h        = '0;
      error_st       = bmpd_pkg::ST_OK;
   endfunction

   // Size fields show only once the header has been accepted
   function automatic bmpd_pkg::bmpd_item_type make_item(logic kind, logic [31:0] argb,
                                                         logic [31:0] x, logic [31:0] y,
                                                         bmpd_pkg::bmpd_status_type st,
                                                         logic last);
      bmpd_pkg::bmpd_item_type it;
      logic                    hdr_ok;
      hdr_ok = (phase == PH_SKIP) || (phase == PH_PIXELS) || (phase == PH_DONE);
      it.item_kind     = kind;
      it.pixel_argb    = argb;
      it.pixel_x       = x[bmpd_pkg::COORD_W-1:0];
      it.pixel_y       = y[bmpd_pkg::COORD_W-1:0];
      it.image_width   = hdr_ok ? width_r[bmpd_pkg::DIM_W-1:0] : '0;
      it.image_height  = hdr_ok ? height_r[bmpd_pkg::DIM_W-1:0] : '0;
      it.decode_status = st;
      it.last_item     = last;
      return it;
   endfunction

   function automatic string item_text(bmpd_pkg::bmpd_item_type it);
      return $sformatf("kind=%0d argb=%08h x=%0d y=%0d w=%0d h=%0d status=%0d last=%0d",
                       it.item_kind, it.pixel_argb, it.pixel_x, it.pixel_y,
                       it.image_width, it.image_height, it.decode_status, it.last_item);
   endfunction

   // Unpack one byte of pixel data; the third byte of a triple emits a pixel
   function automatic void take_pixel_byte(logic [7:0] b);
      logic [31:0] data_bytes;
      logic [31:0] padded_len;
      logic [31:0] x;
      logic [31:0] y;
      logic [7:0]  alpha;
      data_bytes = width_r * 32'd3;
      padded_len = ((data_bytes + 32'd3) / 32'd4) * 32'd4;
      if (row_byte < data_bytes) begin
         case (row_byte % 32'd3)
            32'd0: blue_h = b;
            32'd1: green_h = b;
            default: begin
               x = row_byte / 32'd3;
               y = rows_top_first ? row_idx : height_r - 32'd1 - row_idx;
               alpha = (key_enable && b == bmpd_pkg::BYTE_MAX &&
                        green_h == bmpd_pkg::BYTE_MIN &&
                        blue_h == bmpd_pkg::BYTE_MAX) ? bmpd_pkg::ALPHA_CLEAR
                                                      : bmpd_pkg::ALPHA_OPAQUE;
               decoded_q.insert(decoded_q.size(),
                                make_item(bmpd_pkg::KIND_PIXEL, {alpha, b, green_h, blue_h},
                                          x, y, bmpd_pkg::ST_OK, 1'b0));
            end
         endcase
      end
      // Drop row padding and advance to the next row
      row_byte++;
      if (row_byte >= padded_len) begin
         row_byte = '0;
         row_idx++;
         if (row_idx >= height_r) phase = PH_DONE;
      end
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic eof);
      bmpd_pkg::bmpd_status_type st;
      case (phase)
         PH_HEADER: begin
            field_acc = {b, field_acc[31:8]};
            if ((file_pos == bmpd_pkg::POS_SIG_B && b != bmpd_pkg::SIG_B) ||
                (file_pos == bmpd_pkg::POS_SIG_M && b != bmpd_pkg::SIG_M)) begin
               error_st = bmpd_pkg::ST_BAD_SIG;
               phase    = PH_ERROR;
            end else begin
               if (file_pos == bmpd_pkg::POS_OFFSET_LAST) pix_offset = field_acc;
               if (file_pos == bmpd_pkg::POS_WIDTH_LAST)
                  width_r = field_acc[31] ? '0 : field_acc;
               if (file_pos == bmpd_pkg::POS_HEIGHT_LAST) begin
                  rows_top_first = field_acc[31];
                  height_r = field_acc[31] ? ~field_acc + 32'd1 : field_acc;
               end
               if (file_pos == bmpd_pkg::POS_BPP_LAST) bpp_seen = field_acc[31:16];
               if (file_pos == bmpd_pkg::POS_COMP_LAST) comp_seen = field_acc;
               // Validate the whole header on its last byte
               if (file_pos == bmpd_pkg::HDR_LAST) begin
                  if (bpp_seen == bmpd_pkg::BPP_24 && comp_seen == '0 &&
                      width_r >= 32'd1 && width_r <= bmpd_pkg::MAX_DIM &&
                      height_r >= 32'd1 && height_r <= bmpd_pkg::MAX_DIM &&
                      pix_offset >= bmpd_pkg::HDR_LEN) begin
                     phase = (pix_offset == bmpd_pkg::HDR_LEN) ? PH_PIXELS : PH_SKIP;
                  end else begin
                     error_st = bmpd_pkg::ST_UNSUPPORTED;
                     phase    = PH_ERROR;
                  end
               end
            end
         end
         PH_SKIP: begin
            if (file_pos == pix_offset) begin
               phase = PH_PIXELS;
               take_pixel_byte(b);
            end
         end
         PH_PIXELS: take_pixel_byte(b);
         default: ;
      endcase
      if (file_pos != '1) file_pos++;

      // Close the file with a status item and start over
      if (eof) begin
         if (error_st != bmpd_pkg::ST_OK) st = error_st;
         else if (phase == PH_DONE) st = bmpd_pkg::ST_OK;
         else st = bmpd_pkg::ST_TRUNCATED;
         decoded_q.insert(decoded_q.size(),
                          make_item(bmpd_pkg::KIND_STATUS, '0, '0, '0, st, 1'b1));
         clear_parser();
      end
   endfunction

   always @(posedge clock) begin
      bmpd_pkg::bmpd_item_type got;
      bmpd_pkg::bmpd_item_type want;
      logic                    bad;
      if (reset) begin
         key_enable = 1'b0;
         clear_parser();
         decoded_q = {};
      end else begin
         if (csr_mon.valid && csr_mon.ready) key_enable = csr_mon.color_key_enable;

         // Compare the result transaction with the oldest decoded item
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.item_kind     = rsp_mon.item_kind;
            got.pixel_argb    = rsp_mon.pixel_argb;
            got.pixel_x       = rsp_mon.pixel_x;
            got.pixel_y       = rsp_mon.pixel_y;
            got.image_width   = rsp_mon.image_width;
            got.image_height  = rsp_mon.image_height;
            got.decode_status = bmpd_pkg::bmpd_status_type'(rsp_mon.decode_status);
            got.last_item     = rsp_mon.last_item;
            if (decoded_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with nothing awaited: %s", $realtime, item_text(got));
            end else begin
               want = decoded_q.pop_front();
               bad = (got.item_kind !== want.item_kind) ||
                     (got.pixel_argb !== want.pixel_argb) ||
                     (got.pixel_x !== want.pixel_x) ||
                     (got.pixel_y !== want.pixel_y) ||
                     (got.image_width !== want.image_width) ||
                     (got.image_height !== want.image_height) ||
                     (got.decode_status !== want.decode_status) ||
                     (got.last_item !== want.last_item);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch, expected %s", $realtime, item_text(want));
                     $display("%0t:           actual   %s", $realtime, item_text(got));
                  end
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            decode_byte(req_mon.file_byte, req_mon.end_of_file);
      end
      items_awaited <= decoded_q.size();
   end

endmodule

@@ sim/tb_bmp24_to_argb_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp24_to_argb_decoder
// Streams BMP files into the decoder: a directed set covering size limits,
// every rejection reason, truncation points and color keying, then random
// small files, mostly well formed, under four idle and stall patterns.
// The checker predicts every pixel and status transaction.
// ----------------------------------------------------------------------------

module tb_bmp24_to_argb_decoder;

   localparam int STALL_LIMIT  = 5000;
   localparam int PHASE_BYTES  = 80;
   localparam int PAD_LIMIT    = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         bytes_sent = 0;
   int         mismatch_count;
   int         items_awaited;
   logic [7:0] file_bytes[$];

   bmpd_req_if req_bus ();
   bmpd_rsp_if rsp_bus ();
   bmpd_csr_if csr_bus ();

   bmp24_to_argb_decoder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   bmpd_decode_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .items_awaited  (items_awaited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // End the run when no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // Build a file: header fields as given, then padding up to a pixel offset of at
   // most PAD_LIMIT and, for a valid header within that limit, the full pixel array
   function automatic void make_file(logic [31:0] w, logic [31:0] h, logic [15:0] bpp,
                                     logic [31:0] comp, logic [31:0] offset);
      logic [31:0] mag;
      logic [31:0] row_len;
      logic [23:0] pix;
      file_bytes = {};
      for (int i = 0; i < bmpd_pkg::HDR_LEN; i++)
         file_bytes.insert(file_bytes.size(), 8'($urandom));
      file_bytes[0] = bmpd_pkg::SIG_B;
      file_bytes[1] = bmpd_pkg::SIG_M;
      for (int i = 0; i < 4; i++) begin
         file_bytes[10 + i] = offset[8*i +: 8];
         file_bytes[18 + i] = w[8*i +: 8];
         file_bytes[22 + i] = h[8*i +: 8];
         file_bytes[30 + i] = comp[8*i +: 8];
      end
      file_bytes[28] = bpp[7:0];
      file_bytes[29] = bpp[15:8];
      mag = h[31] ? ~h + 32'd1 : h;
      if (offset <= PAD_LIMIT)
         while (file_bytes.size() < offset) file_bytes.insert(file_bytes.size(), 8'($urandom));
      if (bpp == bmpd_pkg::BPP_24 && comp == '0 && w >= 32'd1 && w <= bmpd_pkg::MAX_DIM &&
          mag >= 32'd1 && mag <= bmpd_pkg::MAX_DIM && offset >= bmpd_pkg::HDR_LEN &&
          offset <= PAD_LIMIT) begin
         row_len = ((w * 32'd3 + 32'd3) / 32'd4) * 32'd4;
         for (int r = 0; r < mag; r++) begin
            // Bias toward magenta and its one-bit neighbors
            for (int c = 0; c < w; c++) begin
               pix = 24'($urandom);
               case ($urandom_range(0, 7))
                  0, 1: pix = {bmpd_pkg::BYTE_MAX, bmpd_pkg::BYTE_MIN, bmpd_pkg::BYTE_MAX};
                  2: pix = {bmpd_pkg::BYTE_MAX, bmpd_pkg::BYTE_MIN, bmpd_pkg::BYTE_MAX} ^
                           (24'd1 << $urandom_range(0, 23));
                  default: ;
               endcase
               file_bytes.insert(file_bytes.size(), pix[7:0]);
               file_bytes.insert(file_bytes.size(), pix[15:8]);
               file_bytes.insert(file_bytes.size(), pix[23:16]);
            end
            repeat (row_len - w * 32'd3) file_bytes.insert(file_bytes.size(), 8'($urandom));
         end
      end else begin
         repeat ($urandom_range(0, 16)) file_bytes.insert(file_bytes.size(), 8'($urandom));
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.file_byte   <= b;
      req_bus.end_of_file <= eof;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   // Hold the byte channel until every awaited result has arrived
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (items_awaited != 0);
   endtask

   // Send the first cut bytes, marking the last one as end of file
   task automatic send_file(input int cut, input int pause_at);
      for (int i = 0; i < cut; i++) begin
         if (i == pause_at) settle();
         send_byte(file_bytes[i], i == cut - 1);
      end
   endtask

   task automatic send_whole(input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] bpp, input logic [31:0] comp,
                             input logic [31:0] offset);
      make_file(w, h, bpp, comp, offset);
      send_file(file_bytes.size(), -1);
   endtask

   // Write the color key only with the decoder idle
   task automatic write_key(input logic en);
      settle();
      repeat (4) @(posedge clock);
      csr_bus.valid            <= 1'b1;
      csr_bus.color_key_enable <= en;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [31:0] w;
      logic [31:0] h;
      logic [31:0] mag;
      logic [31:0] comp;
      logic [31:0] offset;
      logic [15:0] bpp;
      int          sel;
      int          cut;
      int          pause_at;
      int          phase_start;

      req_bus.valid            <= 1'b0;
      req_bus.file_byte        <= '0;
      req_bus.end_of_file      <= 1'b0;
      csr_bus.valid            <= 1'b0;
      csr_bus.color_key_enable <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed files, light idling
      send_idle_pct = 21;
      stall_pct     = 21;
      write_key(1'b0);
      // magenta stays opaque with keying off
      send_whole(2, 2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      write_key(1'b1);
      // pause mid-pixel data until all results are back
      make_file(3, 2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_file(file_bytes.size(), 60);
      // top-down with skipped bytes before the pixels
      send_whole(1, -32'd3, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN + 32'd4);
      // size limits, cut short after the first pixels
      make_file(bmpd_pkg::MAX_DIM, 1, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_file(bmpd_pkg::HDR_LEN + 12, -1);
      make_file(1, bmpd_pkg::MAX_DIM, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_file(bmpd_pkg::HDR_LEN + 12, -1);
      make_file(1, -bmpd_pkg::MAX_DIM, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_file(bmpd_pkg::HDR_LEN + 12, -1);
      // bad signature on either byte, even in a short file
      make_file(2, 2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      file_bytes[0] = bmpd_pkg::SIG_B ^ 8'h01;
      send_file(file_bytes.size(), -1);
      make_file(2, 2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      file_bytes[1] = bmpd_pkg::BYTE_MIN;
      send_file(2, -1);
      // file ends after one byte
      send_file(1, -1);
      // rejected headers
      send_whole(2, 2, 16'd32, '0, bmpd_pkg::HDR_LEN);
      send_whole(2, 2, bmpd_pkg::BPP_24, 32'd1, bmpd_pkg::HDR_LEN);
      send_whole(0, 2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_whole(bmpd_pkg::MAX_DIM + 32'd1, 1, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_whole(32'hFFFF_FFFF, 1, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_whole(2, 0, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_whole(1, -(bmpd_pkg::MAX_DIM + 32'd1), bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_whole(1, 32'h8000_0000, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_whole(2, 2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN - 32'd1);
      // truncation: at the header end, in the skip area, mid row, in padding
      make_file(3, 2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_file(bmpd_pkg::HDR_LEN, -1);
      make_file(2, 1, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN + 32'd6);
      send_file(bmpd_pkg::HDR_LEN + 3, -1);
      make_file(3, 2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      send_file(bmpd_pkg::HDR_LEN + 5, -1);
      send_file(bmpd_pkg::HDR_LEN + 10, -1);
      // pixel offset never reached
      send_whole(1, 1, bmpd_pkg::BPP_24, '0, 32'hFFFF_FFF0);
      // extra bytes after the last row
      make_file(2, 1, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);
      repeat (3) file_bytes.insert(file_bytes.size(), 8'($urandom));
      send_file(file_bytes.size(), -1);
      // end of file on the last pixel byte gives two results at once
      send_whole(4, -32'd2, bmpd_pkg::BPP_24, '0, bmpd_pkg::HDR_LEN);

      // Random files under each idle pattern
      for (int ph = 0; ph < 4; ph++) begin
         write_key((ph % 2) == 1);
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            sel    = $urandom_range(0, 99);
            w      = $urandom_range(1, 6);
            mag    = $urandom_range(1, 4);
            h      = $urandom_range(0, 1) ? ~mag + 32'd1 : mag;
            offset = ($urandom_range(0, 3) == 0) ? bmpd_pkg::HDR_LEN + $urandom_range(1, 8)
                                                 : bmpd_pkg::HDR_LEN;
            bpp    = bmpd_pkg::BPP_24;
            comp   = '0;
            // break one header field
            if (sel < 10) begin
               case ($urandom_range(0, 6))
                  0: bpp = 16'($urandom_range(0, 23));
                  1: comp = $urandom | 32'd1;
                  2: w = $urandom_range(0, 1) ? 32'd0 : ($urandom | 32'h8000_0000);
                  3: w = bmpd_pkg::MAX_DIM + $urandom_range(1, 100);
                  4: h = $urandom_range(0, 1) ? 32'd0 : 32'h8000_0000;
                  5: begin
                     mag = bmpd_pkg::MAX_DIM + $urandom_range(1, 100);
                     h   = $urandom_range(0, 1) ? mag : ~mag + 32'd1;
                  end
                  default: offset = $urandom_range(0, 53);
               endcase
            end
            make_file(w, h, bpp, comp, offset);
            cut = file_bytes.size();
            if (sel >= 10 && sel < 16) begin
               // corrupt the signature
               file_bytes[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
               if ($urandom_range(0, 1) == 1) cut = $urandom_range(1, cut);
            end else if (sel >= 16 && sel < 28) begin
               cut = $urandom_range(1, cut - 1);
            end else if (sel >= 28 && sel < 32) begin
               // plain noise
               file_bytes = {};
               cut = $urandom_range(1, 60);
               repeat (cut) file_bytes.insert(file_bytes.size(), 8'($urandom));
            end else if (sel >= 32 && sel < 48) begin
               repeat ($urandom_range(1, 6)) begin
                  file_bytes.insert(file_bytes.size(), 8'($urandom));
                  cut++;
               end
            end
            pause_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, cut - 1) : -1;
            send_file(cut, pause_at);
         end
      end

      // Drain and let the pipeline go quiet
      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && items_awaited == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ bmp24_to_argb_decoder.f @@
sv/bmpd_pkg.sv
sv/bmpd_if.sv
sv/bmpd_parser.sv
sv/bmpd_out_queue.sv
sv/bmp24_to_argb_decoder.sv
sim/bmpd_decode_checker.sv
sim/tb_bmp24_to_argb_decoder.sv
